// ----- design/php_pkg.sv -----
package php_pkg;

	localparam int MaxStuffingDefault = 16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  stream_code;
		logic        mpeg2_syntax;
		logic        pts_valid;
		logic [32:0] pts_value;
		logic        dts_valid;
		logic [32:0] dts_value;
		logic [8:0]  header_length;
		logic [15:0] payload_length;
	} out_word_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} tok_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_START = 3'd1;
	localparam logic [2:0] ST_SCRAMBLED = 3'd2;
	localparam logic [2:0] ST_STUFFING  = 3'd3;
	localparam logic [2:0] ST_UNDERFLOW = 3'd4;
	localparam logic [2:0] ST_TRUNCATED = 3'd5;

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_SC      = 4'd1;
	localparam logic [3:0] PH_SID     = 4'd2;
	localparam logic [3:0] PH_LENHI   = 4'd3;
	localparam logic [3:0] PH_LENLO   = 4'd4;
	localparam logic [3:0] PH_FIRST   = 4'd5;
	localparam logic [3:0] PH_M1LEAD  = 4'd6;
	localparam logic [3:0] PH_M1STD2  = 4'd7;
	localparam logic [3:0] PH_M1HEAD  = 4'd8;
	localparam logic [3:0] PH_M1TS    = 4'd9;
	localparam logic [3:0] PH_M2FLAGS = 4'd10;
	localparam logic [3:0] PH_M2HDL   = 4'd11;
	localparam logic [3:0] PH_M2OPT   = 4'd12;
	localparam logic [3:0] PH_DONE    = 4'd13;

	function automatic logic [32:0] ts_byte(input logic [32:0] acc, input logic [3:0] k,
			input logic [7:0] b);
		logic [32:0] r;
		r = acc;
		case (k)
			4'd0: r = {b[3:1], 30'd0};
			4'd1: r = acc | {3'd0, b, 22'd0};
			4'd2: r = acc | {11'd0, b[7:1], 15'd0};
			4'd3: r = acc | {18'd0, b, 7'd0};
			4'd4: r = acc | {26'd0, b[7:1]};
			default: r = acc;
		endcase
		return r;
	endfunction

endpackage

// ----- design/php_front.sv -----
module php_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              stall,
	input  php_pkg::in_word_t data,
	output logic              q_valid,
	input  logic              q_pop,
	output php_pkg::tok_t     q_data
);
	import php_pkg::*;

	// two-entry queue between front and back
	tok_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign stall   = (cnt_q == 2'd2);
	assign push    = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{data_byte: data.data_byte, packet_start: data.packet_start};
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) cnt_q == 2'd2 |-> !push;
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != 2'd0) else $error("queue underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");

endmodule

// ----- design/php_back.sv -----
module php_back #(
	parameter int MAX_STUFFING = php_pkg::MaxStuffingDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  php_pkg::tok_t      q_data,
	output logic               out_valid,
	input  logic               out_stall,
	output php_pkg::out_word_t out_data
);
	import php_pkg::*;

	logic [8:0]  pos_q;
	logic [3:0]  ph_q;
	logic [7:0]  sid_q;
	logic [15:0] len_q;
	logic [7:0]  flag_q;
	logic [7:0]  hdl_q;
	logic [4:0]  stuff_q;
	logic [32:0] pts_q, dts_q;
	logic        ov_q;
	out_word_t   od_q;

	logic [8:0]  pos_n;
	logic [3:0]  ph_n;
	logic [7:0]  sid_n, flag_n, hdl_n;
	logic [15:0] len_n;
	logic [4:0]  stuff_n;
	logic [32:0] pts_n, dts_n;
	logic        emit;
	out_word_t   res;
	logic        fin, fin_mp2, fin_pv, fin_dv;
	logic        err;
	logic [2:0]  err_st;
	logic        err_mp2;
	logic [7:0]  b;
	logic [8:0]  hlen, off;
	logic [15:0] over;
	logic        both;
	logic [8:0]  k;

	assign q_pop     = q_valid && (!ov_q || !out_stall);
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign b         = q_data.data_byte;
	assign hlen      = pos_n + 9'd1;
	assign over      = {7'd0, hlen} - 16'd6;

	always_comb begin
		pos_n = pos_q; ph_n = ph_q; sid_n = sid_q; len_n = len_q; flag_n = flag_q;
		hdl_n = hdl_q; stuff_n = stuff_q; pts_n = pts_q; dts_n = dts_q;
		emit = 1'b0; fin = 1'b0; fin_mp2 = 1'b0; fin_pv = 1'b0; fin_dv = 1'b0;
		err = 1'b0; err_st = ST_OK; err_mp2 = 1'b0;
		res = '0;
		off = '0; both = 1'b0; k = '0;
		if (q_data.packet_start) begin
			if (ph_q != PH_IDLE && ph_q != PH_DONE) begin
				emit = 1'b1;
				res.status = ST_TRUNCATED;
				res.stream_code = sid_q;
				res.mpeg2_syntax = (ph_q >= PH_M2FLAGS && ph_q <= PH_M2OPT);
				res.header_length = pos_q + 9'd1;
			end
			pos_n = '0; ph_n = PH_SC; sid_n = '0; len_n = '0; hdl_n = '0;
			stuff_n = '0; pts_n = '0; dts_n = '0;
			flag_n = {7'd0, b != 8'd0};
		end else if (ph_q != PH_IDLE && ph_q != PH_DONE) begin
			pos_n = pos_q + 9'd1;
			case (ph_q)
				PH_SC: begin
					if (pos_n == 9'd1) begin
						if (b != 8'd0) flag_n[0] = 1'b1;
					end else begin
						if (flag_q[0] || b != 8'd1) begin
							err = 1'b1; err_st = ST_BAD_START;
						end else ph_n = PH_SID;
					end
				end
				PH_SID: begin sid_n = b; ph_n = PH_LENHI; end
				PH_LENHI: begin len_n = {b, 8'd0}; ph_n = PH_LENLO; end
				PH_LENLO: begin len_n = {len_q[15:8], b}; ph_n = PH_FIRST; end
				PH_FIRST, PH_M1LEAD, PH_M1HEAD: begin
					if (ph_q == PH_FIRST && b[7:6] == 2'b10) begin
						if (b[5:4] != 2'b00) begin
							err = 1'b1; err_st = ST_SCRAMBLED; err_mp2 = 1'b1;
						end else ph_n = PH_M2FLAGS;
					end else if (ph_q != PH_M1HEAD && b[7]) begin
						if ({27'd0, stuff_q} >= MAX_STUFFING) begin
							err = 1'b1; err_st = ST_STUFFING;
						end else begin
							stuff_n = stuff_q + 5'd1; ph_n = PH_M1LEAD;
						end
					end else if (ph_q != PH_M1HEAD && b[7:6] == 2'b01) begin
						ph_n = PH_M1STD2;
					end else if (b[7:4] == 4'h2 || b[7:4] == 4'h3) begin
						flag_n = b; hdl_n = 8'd1; pts_n = ts_byte('0, 4'd0, b);
						dts_n = '0; ph_n = PH_M1TS;
					end else fin = 1'b1;
				end
				PH_M1STD2: ph_n = PH_M1HEAD;
				PH_M1TS: begin
					both = (flag_q[7:4] == 4'h3);
					if (hdl_q < 8'd5) pts_n = ts_byte(pts_q, hdl_q[3:0], b);
					else dts_n = ts_byte(dts_q, hdl_q[3:0] - 4'd5, b);
					k = {1'b0, hdl_q} + 9'd1;
					hdl_n = k[7:0];
					if (k >= (both ? 9'd10 : 9'd5)) begin
						fin = 1'b1; fin_pv = 1'b1; fin_dv = both;
					end
				end
				PH_M2FLAGS: begin flag_n = b; ph_n = PH_M2HDL; end
				PH_M2HDL: begin
					hdl_n = b; pts_n = '0; dts_n = '0;
					if (b == 8'd0) begin fin = 1'b1; fin_mp2 = 1'b1; end
					else ph_n = PH_M2OPT;
				end
				PH_M2OPT: begin
					off = pos_n - 9'd9;
					if (off < 9'd5) pts_n = ts_byte(pts_q, off[3:0], b);
					else if (off < 9'd10) dts_n = ts_byte(dts_q, off[3:0] - 4'd5, b);
					if (off + 9'd1 >= {1'b0, hdl_q}) begin
						fin = 1'b1; fin_mp2 = 1'b1;
						fin_pv = flag_q[7] && hdl_q >= 8'd5;
						fin_dv = flag_q[7:6] == 2'b11 && hdl_q >= 8'd10;
					end
				end
				default: ph_n = PH_DONE;
			endcase
			if (fin) begin
				err_mp2 = fin_mp2;
				if (len_q != 16'd0 && over > len_q) begin
					err = 1'b1; err_st = ST_UNDERFLOW;
				end else begin
					emit = 1'b1; ph_n = PH_DONE;
					res.status = ST_OK;
					res.stream_code = sid_n;
					res.mpeg2_syntax = fin_mp2;
					res.pts_valid = fin_pv;
					res.pts_value = fin_pv ? pts_n : '0;
					res.dts_valid = fin_dv;
					res.dts_value = fin_dv ? dts_n : '0;
					res.header_length = hlen;
					res.payload_length = (len_q == 16'd0) ? 16'd0 : len_q - over;
				end
			end
			if (err) begin
				emit = 1'b1; ph_n = PH_DONE;
				res = '0;
				res.status = err_st;
				res.stream_code = sid_n;
				res.mpeg2_syntax = err_mp2;
				res.header_length = hlen;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ph_q <= PH_IDLE; sid_q <= '0; len_q <= '0; flag_q <= '0;
			hdl_q <= '0; stuff_q <= '0; pts_q <= '0; dts_q <= '0; ov_q <= 1'b0;
		end else begin
			ov_q <= (q_pop && emit) || (ov_q && out_stall);
			if (q_pop) begin
				pos_q <= pos_n; ph_q <= ph_n; sid_q <= sid_n; len_q <= len_n;
				flag_q <= flag_n; hdl_q <= hdl_n; stuff_q <= stuff_n;
				pts_q <= pts_n; dts_q <= dts_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) od_q <= res;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |=> ov_q && $stable(od_q)) else $error("result lost");
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && emit |-> !ov_q || !out_stall) else $error("result overwritten");
	a_stuff: assert property (@(posedge clk) disable iff (!arst_n)
		{27'd0, stuff_q} <= MAX_STUFFING) else $error("stuffing count overrun");

endmodule

// ----- design/pes_header_parser_unit.sv -----
// PES header parser: takes one packet byte per cycle while not stalled (packet_start on the
// first byte) and emits one descriptor per packet when the header ends, an error is found or
// the next packet cuts the header short. A byte passes a two-word queue and then the parse
// state machine, which handles one byte per cycle while the result is not stalled, so the
// sustained rate is one byte per clock; descriptors are registered in the result register.
// Input stall rises only when the queue is full behind a stalled result.
module pes_header_parser_unit #(
	parameter int MAX_STUFFING = php_pkg::MaxStuffingDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  php_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output php_pkg::out_word_t out_data
);
	import php_pkg::*;

	logic q_valid, q_pop;
	tok_t q_data;

	php_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall), .data(in_data),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	php_back #(.MAX_STUFFING(MAX_STUFFING)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule
